/* src/lru_lookup_fill_cache_core_assert.svh */
// Assertion macros shared by the cache core RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef LRU_LOOKUP_FILL_CACHE_CORE_ASSERT_SVH
`define LRU_LOOKUP_FILL_CACHE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRUFC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRUFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/lrufc_pkg.sv */
// Package for the LRU lookup/fill cache core: sizes, key mask, state type and
// the structs passed between the scan unit, the rank file and the top level.
// No dependencies.
`timescale 1ns / 1ps

package lrufc_pkg;

   localparam int ENTRIES  = 8;
   localparam int KEY_BITS = 48;
   localparam int KEY_W    = 48;
   localparam int DATA_W   = 32;
   localparam int CAP_W    = 4;

   localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (CAP_W > OCC_W) ? CAP_W : OCC_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

   // Only the low KEY_BITS bits of a key take part in matching.
   localparam logic [KEY_W-1:0] KEY_MASK =
      {KEY_W{1'b1}} >> ((KEY_BITS >= KEY_W) ? 0 : (KEY_W - KEY_BITS));

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic             clear;
      logic             probe;
      logic [IDX_W-1:0] idx;
   } scan_ctl_type;

   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [DATA_W-1:0] hit_data;
      logic [RANK_W-1:0] hit_rank;
      logic              max_found;
      logic [IDX_W-1:0]  max_idx;
      logic [RANK_W-1:0] max_rank;
      logic [KEY_W-1:0]  max_tag;
      logic              free_found;
      logic [IDX_W-1:0]  free_idx;
   } scan_res_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] slot;
      logic [OCC_W-1:0] limit;
      logic             grow;
   } rank_cmd_type;

endpackage

/* src/lrufc_ram.sv */
// Generic single-port RAM with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module lrufc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                           wdata,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/lrufc_scan.sv */
// Shared compare unit: examines one entry per cycle and keeps the first tag
// match, the least recent valid entry and the first free slot.
// Depends on lrufc_pkg.
`timescale 1ns / 1ps

module lrufc_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  lrufc_pkg::scan_ctl_type      ctl,
   input  logic [lrufc_pkg::KEY_W-1:0]  key,
   input  logic [lrufc_pkg::KEY_W-1:0]  rd_tag,
   input  logic [lrufc_pkg::DATA_W-1:0] rd_data,
   input  logic [lrufc_pkg::ENTRIES-1:0] valid,
   input  logic [lrufc_pkg::RANK_W-1:0] rank [lrufc_pkg::ENTRIES],
   output lrufc_pkg::scan_res_type      res
);

   lrufc_pkg::scan_res_type     res_ff;
   lrufc_pkg::scan_res_type     res_in;
   logic                        ent_valid;
   logic [lrufc_pkg::RANK_W-1:0] ent_rank;
   logic                        tag_eq;

   always_comb begin
      res_in    = res_ff;
      ent_valid = valid[ctl.idx];
      ent_rank  = rank[ctl.idx];
      tag_eq    = (rd_tag == key);
      if (ctl.clear) begin
         res_in = '0;
      end else if (ctl.probe) begin
         if (ent_valid && tag_eq && !res_ff.hit) begin
            res_in.hit      = 1'b1;
            res_in.hit_idx  = ctl.idx;
            res_in.hit_data = rd_data;
            res_in.hit_rank = ent_rank;
         end
         if (ent_valid && (!res_ff.max_found || ent_rank > res_ff.max_rank)) begin
            res_in.max_found = 1'b1;
            res_in.max_idx   = ctl.idx;
            res_in.max_rank  = ent_rank;
            res_in.max_tag   = rd_tag;
         end
         if (!ent_valid && !res_ff.free_found) begin
            res_in.free_found = 1'b1;
            res_in.free_idx   = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

/* src/lrufc_rank.sv */
// Valid bits, recency ranks and occupancy count of the cache entries.
// Applies one aging/promote command per item. Depends on lrufc_pkg.
`timescale 1ns / 1ps

module lrufc_rank (
   input  logic                          clock,
   input  logic                          reset,
   input  lrufc_pkg::rank_cmd_type       cmd,
   output logic [lrufc_pkg::ENTRIES-1:0] valid,
   output logic [lrufc_pkg::RANK_W-1:0]  rank [lrufc_pkg::ENTRIES],
   output logic [lrufc_pkg::OCC_W-1:0]   occ
);

   logic [lrufc_pkg::ENTRIES-1:0] valid_ff;
   logic [lrufc_pkg::ENTRIES-1:0] valid_in;
   logic [lrufc_pkg::RANK_W-1:0]  rank_ff [lrufc_pkg::ENTRIES];
   logic [lrufc_pkg::RANK_W-1:0]  rank_in [lrufc_pkg::ENTRIES];
   logic [lrufc_pkg::OCC_W-1:0]   occ_ff;
   logic [lrufc_pkg::OCC_W-1:0]   occ_in;

   // The touched slot becomes most recent; every other valid entry younger
   // than the limit ages by one.
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < lrufc_pkg::ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (cmd.en) begin
            if (cmd.slot == lrufc_pkg::IDX_W'(i)) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i] &&
                         (lrufc_pkg::OCC_W'(rank_ff[i]) < cmd.limit)) begin
               rank_in[i] = rank_ff[i] + lrufc_pkg::RANK_W'(1);
            end
         end
      end
      if (cmd.en && cmd.grow) begin
         occ_in = occ_ff + lrufc_pkg::OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < lrufc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < lrufc_pkg::ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   assign valid = valid_ff;
   assign rank  = rank_ff;
   assign occ   = occ_ff;

endmodule

/* src/lru_lookup_fill_cache_core.sv */
// Top level of the fully associative LRU lookup/fill cache core.
// Depends on lrufc_pkg, lrufc_ram, lrufc_scan, lrufc_rank and the assert header.
`timescale 1ns / 1ps
`include "lru_lookup_fill_cache_core_assert.svh"

// An item is taken when start is high and busy is low. After an item is taken,
// busy stays high while the core passes each entry in turn through the single
// tag comparator reading the tag RAM, then drains the registered RAM read,
// then updates ranks and writes the RAMs. The result appears on the rsp_ ports
// for exactly one cycle with rsp_valid high, in the cycle in which busy drops,
// so a new item may be started in that same cycle; no new item is taken before
// the result of the last one. The receiver cannot stall and must take every
// result.
// The capacity register is written through csr_we/csr_wdata; the user must
// write it only while busy is low, since the block itself does not enforce
// this. Zero acts as one and values above the entry count act as full size.
module lru_lookup_fill_cache_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [lrufc_pkg::KEY_W-1:0]  req_request_key,
   input  logic [lrufc_pkg::DATA_W-1:0] req_fill_value,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [lrufc_pkg::DATA_W-1:0] rsp_result_value,
   output logic                         rsp_evicted,
   output logic [lrufc_pkg::KEY_W-1:0]  rsp_evicted_key,
   input  logic                         csr_we,
   input  logic [lrufc_pkg::CAP_W-1:0]  csr_wdata
);

   lrufc_pkg::state_type          state_ff;
   lrufc_pkg::state_type          state_in;
   logic [lrufc_pkg::OCC_W-1:0]   cnt_ff;
   logic [lrufc_pkg::OCC_W-1:0]   cnt_in;
   logic                          pend_ff;
   logic                          pend_in;
   logic [lrufc_pkg::IDX_W-1:0]   pend_idx_ff;
   logic [lrufc_pkg::IDX_W-1:0]   pend_idx_in;
   logic [lrufc_pkg::KEY_W-1:0]   key_ff;
   logic [lrufc_pkg::KEY_W-1:0]   key_in;
   logic [lrufc_pkg::DATA_W-1:0]  fill_ff;
   logic [lrufc_pkg::DATA_W-1:0]  fill_in;
   logic [lrufc_pkg::CAP_W-1:0]   cap_ff;
   logic [lrufc_pkg::CAP_W-1:0]   cap_in;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_hit_ff;
   logic                          rsp_hit_in;
   logic [lrufc_pkg::DATA_W-1:0]  rsp_value_ff;
   logic [lrufc_pkg::DATA_W-1:0]  rsp_value_in;
   logic                          rsp_evicted_ff;
   logic                          rsp_evicted_in;
   logic [lrufc_pkg::KEY_W-1:0]   rsp_evkey_ff;
   logic [lrufc_pkg::KEY_W-1:0]   rsp_evkey_in;

   logic                          accept;
   logic                          ram_we;
   logic [lrufc_pkg::IDX_W-1:0]   ram_addr;
   logic [lrufc_pkg::KEY_W-1:0]   rd_tag;
   logic [lrufc_pkg::DATA_W-1:0]  rd_data;
   lrufc_pkg::scan_ctl_type       scan_ctl;
   lrufc_pkg::scan_res_type       scan_res;
   lrufc_pkg::rank_cmd_type       rank_cmd;
   logic [lrufc_pkg::ENTRIES-1:0] valid;
   logic [lrufc_pkg::RANK_W-1:0]  rank [lrufc_pkg::ENTRIES];
   logic [lrufc_pkg::OCC_W-1:0]   occ;
   logic [lrufc_pkg::CMP_W-1:0]   eff_cap;
   logic [lrufc_pkg::CMP_W-1:0]   occ_ext;
   logic                          do_evict;
   logic [lrufc_pkg::IDX_W-1:0]   slot;
   logic                          upd_miss_free;
   logic                          upd_evict;

   assign accept = start && (state_ff == lrufc_pkg::ST_IDLE);
   assign busy   = (state_ff != lrufc_pkg::ST_IDLE);

   // Capacity as used for the eviction decision.
   always_comb begin
      eff_cap = lrufc_pkg::CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         eff_cap = lrufc_pkg::CMP_W'(1);
      end else if (lrufc_pkg::CMP_W'(cap_ff) > lrufc_pkg::CMP_W'(lrufc_pkg::ENTRIES)) begin
         eff_cap = lrufc_pkg::CMP_W'(lrufc_pkg::ENTRIES);
      end
   end

   assign occ_ext  = lrufc_pkg::CMP_W'(occ);
   assign do_evict = !scan_res.hit && (occ_ext >= eff_cap) && (occ != '0);

   assign upd_miss_free = (state_ff == lrufc_pkg::ST_UPDATE) && !scan_res.hit && !do_evict;
   assign upd_evict     = (state_ff == lrufc_pkg::ST_UPDATE) && do_evict;

   always_comb begin
      priority if (scan_res.hit) begin
         slot = scan_res.hit_idx;
      end else if (do_evict) begin
         slot = scan_res.max_idx;
      end else begin
         slot = scan_res.free_idx;
      end
   end

   always_comb begin
      cap_in = csr_we ? csr_wdata : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lrufc_pkg::ST_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= lrufc_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      key_ff         <= key_in;
      fill_ff        <= fill_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_evkey_ff   <= rsp_evkey_in;
   end

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      pend_in        = 1'b0;
      pend_idx_in    = pend_idx_ff;
      key_in         = key_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = rsp_hit_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_evkey_in   = rsp_evkey_ff;
      ram_we         = 1'b0;
      ram_addr       = cnt_ff[lrufc_pkg::IDX_W-1:0];
      scan_ctl.clear = 1'b0;
      scan_ctl.probe = pend_ff;
      scan_ctl.idx   = pend_idx_ff;
      rank_cmd.en    = 1'b0;
      rank_cmd.slot  = slot;
      rank_cmd.limit = scan_res.hit ? lrufc_pkg::OCC_W'(scan_res.hit_rank)
                                    : lrufc_pkg::OCC_W'(lrufc_pkg::ENTRIES);
      rank_cmd.grow  = !scan_res.hit && !do_evict;
      unique case (state_ff)
         lrufc_pkg::ST_IDLE: begin
            if (accept) begin
               key_in         = req_request_key & lrufc_pkg::KEY_MASK;
               fill_in        = req_fill_value;
               cnt_in         = '0;
               scan_ctl.clear = 1'b1;
               state_in       = lrufc_pkg::ST_SCAN;
            end
         end
         lrufc_pkg::ST_SCAN: begin
            // A read issued now returns its tag next cycle, so the last
            // entry is compared in the cycle when the count reaches ENTRIES.
            if (cnt_ff == lrufc_pkg::OCC_W'(lrufc_pkg::ENTRIES)) begin
               state_in = lrufc_pkg::ST_UPDATE;
            end else begin
               pend_in     = 1'b1;
               pend_idx_in = cnt_ff[lrufc_pkg::IDX_W-1:0];
               cnt_in      = cnt_ff + lrufc_pkg::OCC_W'(1);
            end
         end
         lrufc_pkg::ST_UPDATE: begin
            ram_addr       = slot;
            ram_we         = !scan_res.hit;
            rank_cmd.en    = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_hit_in     = scan_res.hit;
            rsp_value_in   = scan_res.hit ? scan_res.hit_data : fill_ff;
            rsp_evicted_in = do_evict;
            rsp_evkey_in   = do_evict ? scan_res.max_tag : '0;
            state_in       = lrufc_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrufc_pkg::ST_IDLE;
         end
      endcase
   end

   lrufc_ram #(
      .WIDTH (lrufc_pkg::KEY_W),
      .DEPTH (lrufc_pkg::ENTRIES)
   ) u_tag_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (key_ff),
      .rdata (rd_tag)
   );

   lrufc_ram #(
      .WIDTH (lrufc_pkg::DATA_W),
      .DEPTH (lrufc_pkg::ENTRIES)
   ) u_data_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (fill_ff),
      .rdata (rd_data)
   );

   lrufc_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .key     (key_ff),
      .rd_tag  (rd_tag),
      .rd_data (rd_data),
      .valid   (valid),
      .rank    (rank),
      .res     (scan_res)
   );

   lrufc_rank u_rank (
      .clock (clock),
      .reset (reset),
      .cmd   (rank_cmd),
      .valid (valid),
      .rank  (rank),
      .occ   (occ)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_evicted_key  = rsp_evkey_ff;

   `LRUFC_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `LRUFC_ASSERT_SAME(a_free_slot, upd_miss_free, scan_res.free_found, "miss found no free slot")
   `LRUFC_ASSERT_SAME(a_victim, upd_evict, scan_res.max_found, "eviction without a valid victim")
   `LRUFC_ASSERT_SAME(a_occ_bound, 1'b1, $countones(valid) == int'(occ), "occupancy mismatch")

endmodule
